FILE: design/usb_midi_event_packer_defines.svh
// Assertion helpers used by the checker file.
`ifndef USB_MIDI_EVENT_PACKER_DEFINES_SVH
`define USB_MIDI_EVENT_PACKER_DEFINES_SVH

// Same-cycle implication, masked while reset is active.
`define UMEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("umep check failed: same-cycle rule");

// Next-cycle implication, masked while reset is active.
`define UMEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("umep check failed: next-cycle rule");

`endif

FILE: design/umep_pkg.sv
`default_nettype none
package umep_pkg;

    typedef enum logic [2:0] {
        KIND_NOTE_ON  = 3'd0,
        KIND_NOTE_OFF = 3'd1,
        KIND_CTRL     = 3'd2,
        KIND_SYSEX    = 3'd3,
        KIND_TICK     = 3'd4,
        KIND_FLUSH    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ENQ_QUEUED  = 2'd0,
        ENQ_HELD    = 2'd1,
        ENQ_DROPPED = 2'd2
    } t_enq_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN_RD,
        S_DRAIN_OUT
    } t_state;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_packet;

    localparam logic REPLY_STATUS = 1'b0;
    localparam logic REPLY_PACKET = 1'b1;

    // Code index numbers
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
    localparam logic [3:0] CIN_NOTE_OFF   = 4'h8;
    localparam logic [3:0] CIN_NOTE_ON    = 4'h9;
    localparam logic [3:0] CIN_CTRL       = 4'hB;

    // Status nibbles
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_CTRL     = 4'hB;

    // Most packets one tick may drain
    localparam int MAX_BURST = 16;

endpackage
`default_nettype wire

FILE: design/umep_if.sv
`default_nettype none
interface umep_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] cable;
    logic [3:0] channel;
    logic [7:0] first_data;
    logic [6:0] second_data;
    logic       sysex_last;
    logic       endpoint_busy;

    modport source (
        output valid, kind, cable, channel, first_data, second_data,
               sysex_last, endpoint_busy,
        input  ready
    );
    modport sink (
        input  valid, kind, cable, channel, first_data, second_data,
               sysex_last, endpoint_busy,
        output ready
    );
endinterface

interface umep_res_if;
    logic       valid;
    logic       ready;
    logic       reply_kind;
    logic [1:0] enqueue_status;
    logic [7:0] header_byte;
    logic [7:0] data_byte_one;
    logic [7:0] data_byte_two;
    logic [7:0] data_byte_three;
    logic       burst_end;

    modport source (
        output valid, reply_kind, enqueue_status, header_byte, data_byte_one,
               data_byte_two, data_byte_three, burst_end,
        input  ready
    );
    modport sink (
        input  valid, reply_kind, enqueue_status, header_byte, data_byte_one,
               data_byte_two, data_byte_three, burst_end,
        output ready
    );
endinterface
`default_nettype wire

FILE: design/usb_midi_event_packer.sv
`default_nettype none
// Channel  Dir  Carries
// i_evt    in   one MIDI event, frame tick or flush per transaction
// o_res    out  one enqueue status reply or one drained packet per transaction
//
// A note, control or sysex event gives its status reply in the cycle after it is taken.
// A frame tick drains up to BURST_LIMIT packets, each read through the registered
// read port of the packet ring in S_DRAIN_RD and sent from S_DRAIN_OUT once the output
// register is free; i_evt.ready stays low for the whole burst. A busy tick, a tick on
// an empty ring, flush and unused kinds give no transaction.
// Synchronous active-low reset empties the ring and clears the sysex state.
// o_res holds its transaction while o_res.ready is low; i_evt is taken only when
// the output register is free or being emptied.
module usb_midi_event_packer #(
    parameter int RING_PACKETS  = 64,
    parameter int BURST_PACKETS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    umep_evt_if.sink    i_evt,
    umep_res_if.source  o_res
);
    import umep_pkg::*;

    localparam int PTR_W       = $clog2(RING_PACKETS);
    localparam int BURST_LIMIT = (BURST_PACKETS < MAX_BURST) ? BURST_PACKETS : MAX_BURST;
    localparam int CNT_W       = $clog2(BURST_LIMIT + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_PACKETS - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BURST_LIMIT);

    t_packet r_ring [RING_PACKETS];

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [15:0]        r_sx_hold, n_sx_hold;
    logic [1:0]         r_sx_count, n_sx_count;
    logic               r_sx_disc, n_sx_disc;
    logic [CNT_W-1:0]   r_burst_cnt, n_burst_cnt;
    logic               r_burst_last, n_burst_last;
    t_packet            r_rd_pkt;
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    t_enq_status        r_out_status, n_out_status;
    t_packet            r_out_pkt, n_out_pkt;
    logic               r_out_end, n_out_end;

    logic               w_out_free;
    logic               w_accept;
    logic [PTR_W-1:0]   w_wp_inc;
    logic [PTR_W-1:0]   w_rp_inc;
    logic               w_full;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic               w_push;
    t_packet            w_push_pkt;
    logic [3:0]         w_cab;
    logic [7:0]         w_d1;
    logic [7:0]         w_b0;
    logic [7:0]         w_b1;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_evt.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_evt.valid && i_evt.ready;
    assign w_wp_inc    = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign w_rp_inc    = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign w_full      = (w_wp_inc == r_rp);
    assign w_cnt_inc   = r_burst_cnt + 1'b1;
    assign w_cab       = i_evt.cable;
    assign w_d1        = i_evt.first_data;
    assign w_b0        = r_sx_hold[15:8];
    assign w_b1        = r_sx_hold[7:0];

    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_sx_hold    = r_sx_hold;
        n_sx_count   = r_sx_count;
        n_sx_disc    = r_sx_disc;
        n_burst_cnt  = r_burst_cnt;
        n_burst_last = r_burst_last;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_pkt    = r_out_pkt;
        n_out_end    = r_out_end;
        w_push       = 1'b0;
        w_push_pkt   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_kind'(i_evt.kind))
                        KIND_NOTE_ON, KIND_NOTE_OFF, KIND_CTRL, KIND_SYSEX: begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = REPLY_STATUS;
                            n_out_end    = 1'b0;
                            n_out_status = ENQ_DROPPED;
                            n_out_pkt    = '0;
                        end
                        default: ;
                    endcase

                    unique case (t_kind'(i_evt.kind))
                        KIND_NOTE_ON: begin
                            w_push_pkt = '{{w_cab, CIN_NOTE_ON},
                                           {STAT_NOTE_ON, i_evt.channel},
                                           {1'b0, w_d1[6:0]}, {1'b0, i_evt.second_data}};
                            w_push     = !w_full;
                        end
                        KIND_NOTE_OFF: begin
                            w_push_pkt = '{{w_cab, CIN_NOTE_OFF},
                                           {STAT_NOTE_OFF, i_evt.channel},
                                           {1'b0, w_d1[6:0]}, 8'h00};
                            w_push     = !w_full;
                        end
                        KIND_CTRL: begin
                            w_push_pkt = '{{w_cab, CIN_CTRL},
                                           {STAT_CTRL, i_evt.channel},
                                           {1'b0, w_d1[6:0]}, {1'b0, i_evt.second_data}};
                            w_push     = !w_full;
                        end
                        KIND_SYSEX: begin
                            priority if (r_sx_disc) begin
                                if (i_evt.sysex_last) begin
                                    n_sx_disc = 1'b0;
                                end
                            end else if (!i_evt.sysex_last && r_sx_count < 2'd2) begin
                                if (r_sx_count == 2'd0) begin
                                    n_sx_hold = {w_d1, 8'h00};
                                end else begin
                                    n_sx_hold = {w_b0, w_d1};
                                end
                                n_sx_count   = r_sx_count + 1'b1;
                                n_out_status = ENQ_HELD;
                            end else begin
                                unique case (r_sx_count)
                                    2'd0: w_push_pkt = '{{w_cab, CIN_SYSEX_END1},
                                                         w_d1, 8'h00, 8'h00};
                                    2'd1: w_push_pkt = '{{w_cab, CIN_SYSEX_END2},
                                                         w_b0, w_d1, 8'h00};
                                    default: w_push_pkt = '{{w_cab, i_evt.sysex_last ?
                                                             CIN_SYSEX_END3 :
                                                             CIN_SYSEX_CONT},
                                                            w_b0, w_b1, w_d1};
                                endcase
                                n_sx_hold  = '0;
                                n_sx_count = '0;
                                w_push     = !w_full;
                                if (w_full && !i_evt.sysex_last) begin
                                    n_sx_disc = 1'b1;
                                end
                            end
                        end
                        KIND_TICK: begin
                            if (!i_evt.endpoint_busy && r_rp != r_wp) begin
                                n_state     = S_DRAIN_RD;
                                n_burst_cnt = '0;
                            end
                        end
                        KIND_FLUSH: begin
                            n_rp       = '0;
                            n_wp       = '0;
                            n_sx_hold  = '0;
                            n_sx_count = '0;
                            n_sx_disc  = 1'b0;
                        end
                        default: ;
                    endcase

                    if (w_push) begin
                        n_wp         = w_wp_inc;
                        n_out_status = ENQ_QUEUED;
                        n_out_pkt    = w_push_pkt;
                    end
                end
            end
            S_DRAIN_RD: begin
                // ring read issued this cycle, data lands in r_rd_pkt
                n_rp         = w_rp_inc;
                n_burst_cnt  = w_cnt_inc;
                n_burst_last = (w_cnt_inc == CNT_LIMIT) || (w_rp_inc == r_wp);
                n_state      = S_DRAIN_OUT;
            end
            S_DRAIN_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = REPLY_PACKET;
                    n_out_status = ENQ_QUEUED;
                    n_out_pkt    = r_rd_pkt;
                    n_out_end    = r_burst_last;
                    n_state      = r_burst_last ? S_IDLE : S_DRAIN_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_sx_hold   <= '0;
            r_sx_count  <= '0;
            r_sx_disc   <= 1'b0;
            r_burst_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_sx_hold   <= n_sx_hold;
            r_sx_count  <= n_sx_count;
            r_sx_disc   <= n_sx_disc;
            r_burst_cnt <= n_burst_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_burst_last <= n_burst_last;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_pkt    <= n_out_pkt;
        r_out_end    <= n_out_end;
    end

    // read data is held while the output register stalls
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ring[r_wp] <= w_push_pkt;
        end
        if (r_state == S_DRAIN_RD) begin
            r_rd_pkt <= r_ring[r_rp];
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.reply_kind      = r_out_kind;
    assign o_res.enqueue_status  = r_out_status;
    assign o_res.header_byte     = r_out_pkt.header;
    assign o_res.data_byte_one   = r_out_pkt.b1;
    assign o_res.data_byte_two   = r_out_pkt.b2;
    assign o_res.data_byte_three = r_out_pkt.b3;
    assign o_res.burst_end       = r_out_end;

endmodule
`default_nettype wire

FILE: design/umep_checker.sv
`default_nettype none
`include "usb_midi_event_packer_defines.svh"
module umep_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [2:0] i_kind,
    input wire logic       i_busy,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_reply_kind,
    input wire logic [1:0] i_status,
    input wire logic [7:0] i_header,
    input wire logic [7:0] i_d1,
    input wire logic [7:0] i_d2,
    input wire logic [7:0] i_d3,
    input wire logic       i_end
);
    import umep_pkg::*;

    logic w_in_acc;
    logic w_event;
    logic w_silent;

    assign w_in_acc = i_in_valid && i_in_ready;
    assign w_event  = i_kind == KIND_NOTE_ON || i_kind == KIND_NOTE_OFF ||
                      i_kind == KIND_CTRL || i_kind == KIND_SYSEX;
    // actions that never produce a transaction
    assign w_silent = (i_kind == KIND_TICK && i_busy) || i_kind == KIND_FLUSH ||
                      !(w_event || i_kind == KIND_TICK);

    `UMEP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_reply_kind, i_status, i_header, i_d1, i_d2, i_d3, i_end}))
    `UMEP_ASSERT_NEXT(a_event_reply, i_clk, i_rst_n, w_in_acc && w_event, i_out_valid && i_reply_kind == REPLY_STATUS && !i_end)
    `UMEP_ASSERT_NEXT(a_silent_action, i_clk, i_rst_n, w_in_acc && w_silent, !i_out_valid)
    `UMEP_ASSERT_NOW(a_unqueued_zero, i_clk, i_rst_n, i_out_valid && i_status != ENQ_QUEUED, i_reply_kind == REPLY_STATUS && i_header == 8'h00 && i_d1 == 8'h00 && i_d2 == 8'h00 && i_d3 == 8'h00)

endmodule

bind usb_midi_event_packer umep_checker u_umep_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_evt.valid),
    .i_in_ready   (i_evt.ready),
    .i_kind       (i_evt.kind),
    .i_busy       (i_evt.endpoint_busy),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_reply_kind (o_res.reply_kind),
    .i_status     (o_res.enqueue_status),
    .i_header     (o_res.header_byte),
    .i_d1         (o_res.data_byte_one),
    .i_d2         (o_res.data_byte_two),
    .i_d3         (o_res.data_byte_three),
    .i_end        (o_res.burst_end)
);
`default_nettype wire
